>>> rtl/hfc_pkg.sv
// ----------------------------------------------------------------------------
// hfc_pkg
// Request codes and field widths shared by the format converter files.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package hfc_pkg;

    localparam int REQ_W  = 3;
    localparam int WORD_W = 32;

    typedef logic [REQ_W-1:0]  req_t;
    typedef logic [WORD_W-1:0] word_t;

    // Conversion directions; any other code passes the word through.
    localparam req_t REQ_FP16_TO_F32 = 3'd0;
    localparam req_t REQ_BF16_TO_F32 = 3'd1;
    localparam req_t REQ_F32_TO_FP16 = 3'd2;
    localparam req_t REQ_F32_TO_BF16 = 3'd3;
    localparam req_t REQ_PASS        = 3'd4;

endpackage

`default_nettype wire

>>> rtl/hfc_convert.sv
// ----------------------------------------------------------------------------
// hfc_convert
// Combinational conversion of one word between binary32, binary16, bfloat16.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hfc_convert (
    input  wire hfc_pkg::req_t  req_type,
    input  wire hfc_pkg::word_t data_in,
    output hfc_pkg::word_t      data_out
);

    localparam logic [7:0]  HALF_BIAS_ADJ = 8'd112;
    localparam logic [7:0]  SUB_EXP_BASE  = 8'd103;   // 112 - 9
    localparam logic [7:0]  UFLOW_EXP     = 8'd102;   // 112 - 10
    localparam logic [7:0]  OFLOW_EXP     = 8'd143;   // 112 + 31
    localparam logic [23:0] HALF_RND      = 24'h001000;
    localparam logic [31:0] BF_RND        = 32'h00007FFF;
    localparam logic [14:0] HALF_INF      = 15'h7C00;
    localparam logic [7:0]  F32_EXP_MAX   = 8'hFF;

    // ---- binary16 -> binary32 ----
    logic        h_sign;
    logic [4:0]  h_exp;
    logic [9:0]  h_man;
    logic [3:0]  h_msb;
    logic [3:0]  h_shift;
    logic [10:0] h_norm;
    logic [31:0] widen_res;

    always_comb begin
        h_sign = data_in[15];
        h_exp  = data_in[14:10];
        h_man  = data_in[9:0];
        h_msb  = 4'd0;
        for (int i = 0; i < 10; i++) begin
            if (h_man[i]) begin
                h_msb = 4'(i);
            end
        end
        h_shift = 4'd10 - h_msb;
        h_norm  = {1'b0, h_man} << h_shift;
        if (h_exp == 5'd0) begin
            if (h_man == 10'd0) begin
                widen_res = {h_sign, 31'd0};
            end else begin
                widen_res = {h_sign, SUB_EXP_BASE + {4'd0, h_msb}, h_norm[9:0], 13'd0};
            end
        end else if (h_exp == 5'h1F) begin
            widen_res = {h_sign, F32_EXP_MAX, h_man, 13'd0};
        end else begin
            widen_res = {h_sign, {3'd0, h_exp} + HALF_BIAS_ADJ, h_man, 13'd0};
        end
    end

    // ---- binary32 -> binary16, half-up on magnitude ----
    logic        f_sign;
    logic [7:0]  f_exp;
    logic [22:0] f_man;
    logic [7:0]  sub_shift_w;
    logic [23:0] sub_man;
    logic [23:0] sub_rnd;
    logic [23:0] nrm_rnd;
    logic [7:0]  nrm_exp_w;
    logic [14:0] nrm_sum;
    logic [31:0] narrow_res;

    always_comb begin
        f_sign      = data_in[31];
        f_exp       = data_in[30:23];
        f_man       = data_in[22:0];
        sub_shift_w = (HALF_BIAS_ADJ + 8'd1) - f_exp;     // 1..11 in the subnormal range
        sub_man     = {1'b1, f_man} >> sub_shift_w[3:0];
        sub_rnd     = sub_man + HALF_RND;
        nrm_rnd     = {1'b0, f_man} + HALF_RND;
        nrm_exp_w   = f_exp - HALF_BIAS_ADJ;
        // carry out of the mantissa adds into the exponent field
        nrm_sum     = {nrm_exp_w[4:0], 10'd0} + {4'd0, nrm_rnd[23:13]};
        if (f_exp <= HALF_BIAS_ADJ) begin
            if (f_exp < UFLOW_EXP) begin
                narrow_res = {16'd0, f_sign, 15'd0};
            end else begin
                narrow_res = {16'd0, f_sign, 4'd0, sub_rnd[23:13]};
            end
        end else if (f_exp >= OFLOW_EXP) begin
            narrow_res = {16'd0, f_sign, HALF_INF};
        end else begin
            narrow_res = {16'd0, f_sign, nrm_sum};
        end
    end

    // ---- binary32 -> bfloat16, nearest even, wraps at 32 bits ----
    logic [31:0] bf_sum;

    always_comb begin
        bf_sum = data_in + BF_RND + {31'd0, data_in[16]};
    end

    always_comb begin
        case (req_type)
            hfc_pkg::REQ_FP16_TO_F32: data_out = widen_res;
            hfc_pkg::REQ_BF16_TO_F32: data_out = {data_in[15:0], 16'd0};
            hfc_pkg::REQ_F32_TO_FP16: data_out = narrow_res;
            hfc_pkg::REQ_F32_TO_BF16: data_out = {16'd0, bf_sum[31:16]};
            default:                  data_out = data_in;
        endcase
    end

endmodule

`default_nettype wire

>>> rtl/half_float_format_converter.sv
// ----------------------------------------------------------------------------
// half_float_format_converter
// Per-item conversion between binary32, binary16 and bfloat16.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel s_valid/s_ready carries s_req_type and s_data_in; result
//   channel m_valid/m_ready carries m_data_out. Codes: binary16 to binary32,
//   bfloat16 to binary32, binary32 to binary16, binary32 to bfloat16, and
//   passthrough for every other code. 16-bit values sit in bits 15..0.
//   Two register stages: the item is captured in an input register, the
//   conversion logic sits between it and the result register. m_valid rises
//   once the converted item moves from the input register into the result
//   register; throughput is one item per cycle while the receiver does not
//   stall, set by the single conversion pass between the two stages.
//   A stalled receiver holds the result register; the input stage keeps
//   taking items until it also holds one, so up to two items are in flight.
//   s_ready depends combinationally on m_ready.
//   Synchronous active-low reset empties both stages; no results are shown
//   until new items arrive.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module half_float_format_converter (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 s_valid,
    output logic                s_ready,
    input  wire hfc_pkg::req_t  s_req_type,
    input  wire hfc_pkg::word_t s_data_in,
    output logic                m_valid,
    input  wire                 m_ready,
    output hfc_pkg::word_t      m_data_out
);

    logic           in_valid_reg;
    hfc_pkg::req_t  in_req_reg;
    hfc_pkg::word_t in_data_reg;
    logic           out_valid_reg;
    hfc_pkg::word_t out_data_reg;
    hfc_pkg::word_t conv_next;
    logic           out_free;
    logic           in_free;

    hfc_convert u_convert (
        .req_type (in_req_reg),
        .data_in  (in_data_reg),
        .data_out (conv_next)
    );

    assign out_free = !out_valid_reg || m_ready;
    assign in_free  = !in_valid_reg || out_free;
    assign s_ready  = in_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (in_free) begin
                in_valid_reg <= s_valid;
            end
            if (out_free) begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_free && s_valid) begin
            in_req_reg  <= s_req_type;
            in_data_reg <= s_data_in;
        end
        if (out_free && in_valid_reg) begin
            out_data_reg <= conv_next;
        end
    end

    assign m_valid    = out_valid_reg;
    assign m_data_out = out_data_reg;

endmodule

`default_nettype wire

>>> rtl/hfc_checker.sv
// ----------------------------------------------------------------------------
// hfc_checker
// Port-level checks for the format converter, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hfc_checker (
    input wire                 aclk,
    input wire                 aresetn,
    input wire                 s_valid,
    input wire                 s_ready,
    input wire                 m_valid,
    input wire                 m_ready,
    input wire hfc_pkg::word_t m_data_out
);

    // a held result keeps its value until taken
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data_out))
        else $error("result changed while stalled");

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // an open output side always lets a new item in
    a_ready_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_valid || m_ready) |-> s_ready)
        else $error("input blocked while output side is free");

    // an item accepted while the result side is empty and ready reaches m_valid
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && !m_valid && m_ready |=> ##1 m_valid)
        else $error("result missing after two cycles");

endmodule

bind half_float_format_converter hfc_checker u_hfc_checker (.*);

`default_nettype wire

>>> bench/tb_half_float_format_converter.sv
// ----------------------------------------------------------------------------
// tb_half_float_format_converter
// Self-checking bench for the binary32 / binary16 / bfloat16 converter.
// A directed table covers zeros, infinities, NaNs, subnormals, rounding
// carries, the flush boundary and unused request codes 5 and 7. About 450 random
// words follow on every request code. Each accepted item is predicted
// in-bench and matched in order against the result channel, with random
// gaps on both sides and one long receiver stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_half_float_format_converter;

    localparam int RANDOM_ITEMS    = 450;
    localparam int CALM_ITEMS      = 60;    // tail of the run with no gaps at all
    localparam int STALL_AFTER     = 100;   // items accepted before the long stall
    localparam int STALL_CYCLES    = 48;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int DRAIN_CYCLES    = 8;
    localparam int HALF_EXP_OFFSET = 112;   // binary32 bias minus binary16 bias

    // codes the block does not decode; they pass the word through
    localparam hfc_pkg::req_t REQ_UNUSED_LO = 3'd5;
    localparam hfc_pkg::req_t REQ_UNUSED_HI = 3'd7;

    typedef struct packed {
        hfc_pkg::req_t  req;
        hfc_pkg::word_t word;
        logic           typed;    // result below is the known answer
        hfc_pkg::word_t result;
    } stim_row_t;

    localparam int DIRECTED_COUNT = 25;
    localparam stim_row_t DIRECTED [DIRECTED_COUNT] = '{
        '{hfc_pkg::REQ_FP16_TO_F32, 32'h0000_0000, 1'b1, 32'h0000_0000},
        '{hfc_pkg::REQ_FP16_TO_F32, 32'h0000_8000, 1'b1, 32'h8000_0000},
        '{hfc_pkg::REQ_FP16_TO_F32, 32'hFFFF_3C00, 1'b1, 32'h3F80_0000}, // upper half ignored
        '{hfc_pkg::REQ_FP16_TO_F32, 32'h0000_7C00, 1'b1, 32'h7F80_0000},
        '{hfc_pkg::REQ_FP16_TO_F32, 32'h0000_FC00, 1'b1, 32'hFF80_0000},
        '{hfc_pkg::REQ_FP16_TO_F32, 32'h0000_7E01, 1'b1, 32'h7FC0_2000}, // NaN keeps payload
        '{hfc_pkg::REQ_FP16_TO_F32, 32'h0000_0001, 1'b0, 32'h0},         // smallest subnormal
        '{hfc_pkg::REQ_FP16_TO_F32, 32'h0000_7BFF, 1'b0, 32'h0},
        '{hfc_pkg::REQ_BF16_TO_F32, 32'hABCD_3F80, 1'b1, 32'h3F80_0000},
        '{hfc_pkg::REQ_BF16_TO_F32, 32'h0000_FFFF, 1'b1, 32'hFFFF_0000},
        '{hfc_pkg::REQ_F32_TO_FP16, 32'h3F80_0000, 1'b1, 32'h0000_3C00},
        '{hfc_pkg::REQ_F32_TO_FP16, 32'h8000_0000, 1'b1, 32'h0000_8000},
        '{hfc_pkg::REQ_F32_TO_FP16, 32'h7FC0_0000, 1'b1, 32'h0000_7C00}, // NaN becomes infinity
        '{hfc_pkg::REQ_F32_TO_FP16, 32'hFF80_0000, 1'b1, 32'h0000_FC00},
        '{hfc_pkg::REQ_F32_TO_FP16, 32'h477F_F000, 1'b0, 32'h0},    // carry into infinity
        '{hfc_pkg::REQ_F32_TO_FP16, 32'h387F_F000, 1'b0, 32'h0},    // carry to smallest normal
        '{hfc_pkg::REQ_F32_TO_FP16, 32'hB300_0000, 1'b0, 32'h0},    // 2^-25, last kept value
        '{hfc_pkg::REQ_F32_TO_FP16, 32'h32FF_FFFF, 1'b0, 32'h0},    // flushes to zero
        '{hfc_pkg::REQ_F32_TO_BF16, 32'h3F80_8000, 1'b0, 32'h0},    // tie, even kept bit
        '{hfc_pkg::REQ_F32_TO_BF16, 32'h3F81_8000, 1'b0, 32'h0},    // tie, odd kept bit
        '{hfc_pkg::REQ_F32_TO_BF16, 32'hFFFF_FFFF, 1'b0, 32'h0},    // negative NaN wraps
        '{hfc_pkg::REQ_F32_TO_BF16, 32'h7FFF_FFFF, 1'b0, 32'h0},
        '{hfc_pkg::REQ_PASS,        32'hDEAD_BEEF, 1'b1, 32'hDEAD_BEEF},
        '{REQ_UNUSED_LO,            32'h0000_0000, 1'b1, 32'h0000_0000},
        '{REQ_UNUSED_HI,            32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF}
    };

    logic           aclk = 1'b0;
    logic           aresetn;
    logic           s_valid;
    logic           s_ready;
    hfc_pkg::req_t  s_req_type;
    hfc_pkg::word_t s_data_in;
    logic           m_valid;
    logic           m_ready;
    hfc_pkg::word_t m_data_out;

    // payload side information, travels with the item
    logic           row_typed;
    hfc_pkg::word_t row_result;

    logic           calm_phase;
    logic           stall_active = 1'b0;
    int             items_in     = 0;
    int             results_out  = 0;
    int             quiet_cycles = 0;
    int             error_count  = 0;
    hfc_pkg::word_t pending_words [$];
    hfc_pkg::word_t expected_word;

    always #10 aclk = ~aclk;

    half_float_format_converter u_dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_req_type (s_req_type),
        .s_data_in  (s_data_in),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data_out (m_data_out)
    );

    function automatic hfc_pkg::word_t converted_word(hfc_pkg::req_t req,
                                                      hfc_pkg::word_t word);
        logic [10:0]    mant;
        int             scale;
        hfc_pkg::word_t frac;
        logic [15:0]    sign16;
        hfc_pkg::word_t rounded;
        case (req)
            hfc_pkg::REQ_FP16_TO_F32: begin
                if (word[14:10] == 5'h00) begin
                    if (word[9:0] == 10'h000)
                        return {word[15], 31'b0};
                    // normalize the subnormal
                    mant  = {1'b0, word[9:0]};
                    scale = 1;
                    while (!mant[10]) begin
                        mant  = mant << 1;
                        scale = scale - 1;
                    end
                    return {word[15], 8'(scale + HALF_EXP_OFFSET), mant[9:0], 13'b0};
                end
                if (word[14:10] == 5'h1F)
                    return {word[15], 8'hFF, word[9:0], 13'b0};
                return {word[15], 8'(word[14:10] + 8'(HALF_EXP_OFFSET)), word[9:0], 13'b0};
            end
            hfc_pkg::REQ_BF16_TO_F32: return {word[15:0], 16'h0000};
            hfc_pkg::REQ_F32_TO_FP16: begin
                sign16 = {word[31], 15'b0};
                scale  = int'(word[30:23]) - HALF_EXP_OFFSET;
                if (scale <= 0) begin
                    if (scale < -10)
                        return {16'h0000, sign16};
                    frac = {8'h00, 1'b1, word[22:0]} >> (1 - scale);
                    frac = (frac + 32'h1000) >> 13;
                    return {16'h0000, sign16 | frac[15:0]};
                end
                if (scale >= 31)
                    return {16'h0000, sign16 | 16'h7C00};
                // half-up on magnitude; carry ripples into the exponent
                frac = ({9'b0, word[22:0]} + 32'h1000) >> 13;
                return {16'h0000, sign16 | ((16'(scale) << 10) + frac[15:0])};
            end
            hfc_pkg::REQ_F32_TO_BF16: begin
                rounded = word + 32'h7FFF + {31'b0, word[16]};
                return {16'h0000, rounded[31:16]};
            end
            default: return word;
        endcase
    endfunction

    // scoreboard and watchdog
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                pending_words.push_back(row_typed ? row_result
                                                  : converted_word(s_req_type, s_data_in));
                items_in <= items_in + 1;
            end
            if (m_valid && m_ready) begin
                results_out <= results_out + 1;
                if (pending_words.size() == 0) begin
                    $error("data_out: no item pending, got %h", m_data_out);
                    error_count++;
                end else begin
                    expected_word = pending_words.pop_front();
                    if (m_data_out !== expected_word) begin
                        $error("data_out mismatch: expected %h, actual %h",
                               expected_word, m_data_out);
                        error_count++;
                    end
                end
            end
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Timeout: no handshake for %0d cycles", quiet_cycles);
                $display("Regression FAIL");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // result side: random back-pressure plus one long hold-off
    initial begin
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(posedge aclk);
            if (!calm_phase && !stall_active && items_in >= STALL_AFTER
                    && results_out < STALL_AFTER + 20) begin
                m_ready      <= 1'b0;
                stall_active <= 1'b1;
                repeat (STALL_CYCLES) @(posedge aclk);
                m_ready <= 1'b1;
                wait (results_out >= STALL_AFTER + 20);  // only once per run
                stall_active <= 1'b0;
            end else if (!calm_phase && $urandom_range(0, 7) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge aclk);
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    task automatic offer_item(input hfc_pkg::req_t req, input hfc_pkg::word_t word,
                              input logic typed, input hfc_pkg::word_t result,
                              input logic gaps);
        if (gaps && !stall_active && $urandom_range(0, 4) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_req_type <= req;
        s_data_in  <= word;
        row_typed  <= typed;
        row_result <= result;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    initial begin
        hfc_pkg::req_t  req;
        hfc_pkg::word_t word;
        aresetn    = 1'b0;
        s_valid    = 1'b0;
        s_req_type = hfc_pkg::REQ_PASS;
        s_data_in  = '0;
        row_typed  = 1'b0;
        row_result = '0;
        calm_phase = 1'b0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        for (int k = 0; k < DIRECTED_COUNT; k++)
            offer_item(DIRECTED[k].req, DIRECTED[k].word, DIRECTED[k].typed,
                       DIRECTED[k].result, 1'b1);

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if ($urandom_range(0, 9) == 0)
                req = hfc_pkg::req_t'($urandom_range(REQ_UNUSED_LO, REQ_UNUSED_HI));
            else
                req = hfc_pkg::req_t'($urandom_range(hfc_pkg::REQ_FP16_TO_F32,
                                                     hfc_pkg::REQ_PASS));
            word = $urandom;
            case ($urandom_range(0, 5))
                0: word[30:23] = 8'($urandom_range(97, 145));  // around binary16 range edges
                1: word[14:10] = ($urandom_range(0, 1) != 0) ? 5'h1F : 5'h00;
                2: word[12:0]  = ($urandom_range(0, 1) != 0) ? 13'h1000 : 13'h0FFF;
                3: word[15:0]  = ($urandom_range(0, 1) != 0) ? 16'h8000 : 16'h7FFF;
                4: word[30:23] = ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
                default: ;
            endcase
            if (i == RANDOM_ITEMS - CALM_ITEMS)
                calm_phase <= 1'b1;
            offer_item(req, word, 1'b0, '0,
                       (i < RANDOM_ITEMS - CALM_ITEMS) && ((i / 50) % 3 != 2));
        end
        s_valid <= 1'b0;

        while (pending_words.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (pending_words.size() != 0) begin
            $error("data_out: %0d items never produced a result", pending_words.size());
            error_count++;
        end
        $display("Checked %0d results from %0d items over all eight request codes,",
                 results_out, items_in);
        $display("with directed edge values, random gaps on both sides and one long stall.");
        if (error_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

>>> files.f
rtl/hfc_pkg.sv
rtl/hfc_convert.sv
rtl/half_float_format_converter.sv
rtl/hfc_checker.sv
bench/tb_half_float_format_converter.sv
